// ===== hw/rtl/layered_radiance_propagation_down_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the layered radiance propagation RTL.
// Each macro wraps one clocked, reset-qualified concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef LAYERED_RADIANCE_PROPAGATION_DOWN_DEFINES_SVH
`define LAYERED_RADIANCE_PROPAGATION_DOWN_DEFINES_SVH

// Same-cycle implication.
`define LRP_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lrp assertion failed");

// Next-cycle implication.
`define LRP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lrp assertion failed");

`endif

// ===== hw/rtl/lrp_pkg.sv =====
// ----------------------------------------------------------------------------
// lrp_pkg
// Types, constants and arithmetic helpers for the radiance propagation block.
// ----------------------------------------------------------------------------
package lrp_pkg;

  localparam int unsigned RegionCount = 3;
  localparam int unsigned CoefCount   = RegionCount * RegionCount;
  localparam int unsigned RowW        = $clog2(RegionCount);
  localparam int unsigned CoefW       = 17;
  localparam int unsigned RadW        = 32;
  localparam int unsigned IdxW        = 4;
  localparam int unsigned ProdW       = CoefW + RadW;
  // Three products plus a shifted source fit in 51 bits.
  localparam int unsigned AccW        = ProdW + 2;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdLayer = 1'b1;

  typedef enum logic [1:0] {
    TOP_ZERO,
    TOP_COPY,
    TOP_MIX
  } lrp_top_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX,
    ST_MIX_ACC,
    ST_TOP,
    ST_SOL_MUL,
    ST_SOL_ACC,
    ST_BASE,
    ST_DONE
  } lrp_state_e;

  // Per-cycle control broadcast from the sequencer to every lane.
  typedef struct packed {
    logic            mul_solve;
    logic            acc_clr;
    logic            acc_src;
    logic            acc_add;
    logic            top_ld;
    lrp_top_sel_e    top_sel;
    logic            base_ld;
    logic [RowW-1:0] row;
    logic            layer_clear;
  } lrp_ctl_t;

  // Where a coefficient load lands: lane is the lower region, row the upper.
  typedef struct packed {
    logic            valid;
    logic [RowW-1:0] lane;
    logic [RowW-1:0] row;
  } lrp_slot_t;

  function automatic lrp_slot_t coef_slot(input logic [IdxW-1:0] idx);
    lrp_slot_t s;
    s = '0;
    unique case (idx)
      4'd0: s = '{valid: 1'b1, lane: 2'd0, row: 2'd0};
      4'd1: s = '{valid: 1'b1, lane: 2'd1, row: 2'd0};
      4'd2: s = '{valid: 1'b1, lane: 2'd2, row: 2'd0};
      4'd3: s = '{valid: 1'b1, lane: 2'd0, row: 2'd1};
      4'd4: s = '{valid: 1'b1, lane: 2'd1, row: 2'd1};
      4'd5: s = '{valid: 1'b1, lane: 2'd2, row: 2'd1};
      4'd6: s = '{valid: 1'b1, lane: 2'd0, row: 2'd2};
      4'd7: s = '{valid: 1'b1, lane: 2'd1, row: 2'd2};
      4'd8: s = '{valid: 1'b1, lane: 2'd2, row: 2'd2};
      default: s = '0;
    endcase
    return s;
  endfunction

  // Round half up from Q.32 to Q.16 and clamp to the 32-bit radiance range.
  function automatic logic [RadW-1:0] round_sat(input logic [AccW-1:0] acc);
    logic [AccW:0] s;
    s = {1'b0, acc} + (AccW+1)'(32768);
    if (|s[AccW:RadW+16]) begin
      return '1;
    end
    return s[RadW+15:16];
  endfunction

endpackage

// ===== hw/rtl/lrp_lane.sv =====
// ----------------------------------------------------------------------------
// lrp_lane
// One region lane: holds its overlap column, mixes the radiance entering its
// region and solves base = transmittance * top + source.
// ----------------------------------------------------------------------------
module lrp_lane (
  input  logic                          clk_i,
  input  lrp_pkg::lrp_ctl_t             ctl_i,
  input  logic                          zero_base_i,
  input  logic                          load_i,
  input  logic [lrp_pkg::CoefW-1:0]     trans_i,
  input  logic [lrp_pkg::RadW-1:0]      src_i,
  input  logic                          coef_we_i,
  input  logic [lrp_pkg::RowW-1:0]      coef_row_i,
  input  logic [lrp_pkg::CoefW-1:0]     coef_val_i,
  input  logic [lrp_pkg::RadW-1:0]      operand_i,
  output logic [lrp_pkg::RadW-1:0]      base_o
);

  logic [lrp_pkg::CoefW-1:0] coef_q [lrp_pkg::RegionCount];
  logic [lrp_pkg::CoefW-1:0] trans_q;
  logic [lrp_pkg::RadW-1:0]  src_q;
  logic [lrp_pkg::ProdW-1:0] prod_q, prod_d;
  logic [lrp_pkg::AccW-1:0]  acc_q, acc_d;
  logic [lrp_pkg::RadW-1:0]  top_q, top_d;
  logic [lrp_pkg::RadW-1:0]  base_q, base_d;
  logic [lrp_pkg::CoefW-1:0] coef_rd;
  logic [lrp_pkg::CoefW-1:0] mul_a;
  logic [lrp_pkg::RadW-1:0]  mul_b;

  always_comb begin
    case (ctl_i.row)
      2'd0:    coef_rd = coef_q[0];
      2'd1:    coef_rd = coef_q[1];
      2'd2:    coef_rd = coef_q[2];
      default: coef_rd = coef_q[0];
    endcase
  end

  assign mul_a  = ctl_i.mul_solve ? trans_q : coef_rd;
  assign mul_b  = ctl_i.mul_solve ? top_q : operand_i;
  assign prod_d = {{lrp_pkg::RadW{1'b0}}, mul_a} * {{lrp_pkg::CoefW{1'b0}}, mul_b};

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.acc_clr) begin
      acc_d = '0;
    end else if (ctl_i.acc_src) begin
      acc_d = {3'b000, src_q, 16'h0000};
    end else if (ctl_i.acc_add) begin
      acc_d = acc_q + {2'b00, prod_q};
    end
  end

  always_comb begin
    case (ctl_i.top_sel)
      lrp_pkg::TOP_COPY: top_d = operand_i;
      lrp_pkg::TOP_MIX:  top_d = lrp_pkg::round_sat(acc_q);
      default:           top_d = '0;
    endcase
  end

  assign base_d = zero_base_i ? '0 : lrp_pkg::round_sat(acc_q);

  always_ff @(posedge clk_i) begin
    if (coef_we_i) begin
      case (coef_row_i)
        2'd0:    coef_q[0] <= coef_val_i;
        2'd1:    coef_q[1] <= coef_val_i;
        2'd2:    coef_q[2] <= coef_val_i;
        default: coef_q[0] <= coef_val_i;
      endcase
    end
    if (load_i) begin
      trans_q <= trans_i;
      src_q   <= src_i;
    end
    prod_q <= prod_d;
    acc_q  <= acc_d;
    if (ctl_i.top_ld) begin
      top_q <= top_d;
    end
    if (ctl_i.base_ld) begin
      base_q <= base_d;
    end
  end

  assign base_o = base_q;

endmodule

// ===== hw/rtl/lrp_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrp_ctrl
// Layer sequencer: steps the lanes through mixing and solving, and keeps the
// column flags that decide how the top radiance is formed.
// ----------------------------------------------------------------------------
`include "layered_radiance_propagation_down_defines.svh"

module lrp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_fire_i,
  input  logic              cmd_i,
  input  logic              layer_clear_i,
  input  logic              last_layer_i,
  input  logic              out_free_i,
  output logic              in_ready_o,
  output lrp_pkg::lrp_ctl_t ctl_o,
  output logic              commit_o,
  output logic              emit_o
);

  lrp_pkg::lrp_state_e          state_q, state_d;
  logic [lrp_pkg::RowW-1:0]     cnt_q, cnt_d;
  logic                         clear_q, clear_d;
  logic                         last_q, last_d;
  logic                         prev_clear_q, prev_clear_d;
  logic                         at_top_q, at_top_d;
  logic                         commit;

  assign commit = (state_q == lrp_pkg::ST_DONE) && (out_free_i || !last_q);

  // Next state.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    clear_d      = clear_q;
    last_d       = last_q;
    prev_clear_d = prev_clear_q;
    at_top_d     = at_top_q;
    unique case (state_q)
      lrp_pkg::ST_IDLE: begin
        if (in_fire_i && (cmd_i == lrp_pkg::CmdLayer)) begin
          clear_d = layer_clear_i;
          last_d  = last_layer_i;
          cnt_d   = '0;
          state_d = lrp_pkg::ST_MIX;
        end
      end
      lrp_pkg::ST_MIX: begin
        if (cnt_q == lrp_pkg::RowW'(lrp_pkg::RegionCount - 1)) begin
          cnt_d   = '0;
          state_d = lrp_pkg::ST_MIX_ACC;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      lrp_pkg::ST_MIX_ACC: state_d = lrp_pkg::ST_TOP;
      lrp_pkg::ST_TOP:     state_d = lrp_pkg::ST_SOL_MUL;
      lrp_pkg::ST_SOL_MUL: state_d = lrp_pkg::ST_SOL_ACC;
      lrp_pkg::ST_SOL_ACC: state_d = lrp_pkg::ST_BASE;
      lrp_pkg::ST_BASE:    state_d = lrp_pkg::ST_DONE;
      lrp_pkg::ST_DONE: begin
        if (commit) begin
          state_d      = lrp_pkg::ST_IDLE;
          prev_clear_d = last_q ? 1'b1 : clear_q;
          at_top_d     = last_q;
        end
      end
      default: state_d = lrp_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    ctl_o             = '0;
    ctl_o.top_sel     = lrp_pkg::TOP_ZERO;
    ctl_o.row         = cnt_q;
    ctl_o.layer_clear = clear_q;
    in_ready_o        = 1'b0;
    commit_o          = 1'b0;
    emit_o            = 1'b0;
    unique case (state_q)
      lrp_pkg::ST_IDLE: in_ready_o = 1'b1;
      lrp_pkg::ST_MIX: begin
        // The product of the previous row is added while the next is formed.
        // Only row zero contributes when the layer above was clear.
        ctl_o.acc_clr = (cnt_q == '0);
        ctl_o.acc_add = (cnt_q != '0) && (!prev_clear_q || (cnt_q == 2'd1));
      end
      lrp_pkg::ST_MIX_ACC: ctl_o.acc_add = !prev_clear_q;
      lrp_pkg::ST_TOP: begin
        ctl_o.top_ld = 1'b1;
        if (at_top_q) begin
          ctl_o.top_sel = lrp_pkg::TOP_ZERO;
        end else if (prev_clear_q && clear_q) begin
          ctl_o.top_sel = lrp_pkg::TOP_COPY;
        end else begin
          ctl_o.top_sel = lrp_pkg::TOP_MIX;
        end
      end
      lrp_pkg::ST_SOL_MUL: begin
        ctl_o.mul_solve = 1'b1;
        ctl_o.acc_src   = 1'b1;
      end
      lrp_pkg::ST_SOL_ACC: ctl_o.acc_add = 1'b1;
      lrp_pkg::ST_BASE:    ctl_o.base_ld = 1'b1;
      lrp_pkg::ST_DONE: begin
        commit_o = commit;
        emit_o   = commit && last_q;
      end
      default: in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lrp_pkg::ST_IDLE;
      cnt_q        <= '0;
      clear_q      <= 1'b0;
      last_q       <= 1'b0;
      prev_clear_q <= 1'b1;
      at_top_q     <= 1'b1;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      clear_q      <= clear_d;
      last_q       <= last_d;
      prev_clear_q <= prev_clear_d;
      at_top_q     <= at_top_d;
    end
  end

  `LRP_ASSERT(a_layer_reaches_done,
      in_fire_i && (cmd_i == lrp_pkg::CmdLayer), ##9 (state_q == lrp_pkg::ST_DONE))
  `LRP_ASSERT(a_cnt_only_in_mix, cnt_q != '0, state_q == lrp_pkg::ST_MIX)
  `LRP_ASSERT_NXT(a_last_restarts_column, commit && last_q, at_top_q && prev_clear_q)

endmodule

// ===== hw/rtl/layered_radiance_propagation_down.sv =====
// A layer item steps through mix, mix-accumulate, top, solve-multiply, solve-accumulate, base
// and done, where it commits; only idle takes a new item. Loads go back to back.
// Each lane's shared multiplier forms three overlap products, then the transmittance product.
// A bottom layer waits while the output register holds a result.
// Reset is asynchronous and active low: it starts a new column with zero radiance at the top;
// the overlap matrix holds no defined value until it is loaded.
// ----------------------------------------------------------------------------
// layered_radiance_propagation_down
// Downward radiance propagation through a column of three-region layers.
// ----------------------------------------------------------------------------
`include "layered_radiance_propagation_down_defines.svh"

module layered_radiance_propagation_down (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       cmd_i,
  input  logic [lrp_pkg::IdxW-1:0]   coef_index_i,
  input  logic [lrp_pkg::CoefW-1:0]  coef_value_i,
  input  logic                       layer_clear_i,
  input  logic [lrp_pkg::CoefW-1:0]  trans_clear_i,
  input  logic [lrp_pkg::CoefW-1:0]  trans_cloud_a_i,
  input  logic [lrp_pkg::CoefW-1:0]  trans_cloud_b_i,
  input  logic [lrp_pkg::RadW-1:0]   src_clear_i,
  input  logic [lrp_pkg::RadW-1:0]   src_cloud_a_i,
  input  logic [lrp_pkg::RadW-1:0]   src_cloud_b_i,
  input  logic                       last_layer_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [lrp_pkg::RadW-1:0]   base_clear_o,
  output logic [lrp_pkg::RadW-1:0]   base_cloud_a_o,
  output logic [lrp_pkg::RadW-1:0]   base_cloud_b_o
);

  // Each region has its own lane. Lane l owns column l of the overlap matrix,
  // so during mixing every lane reads its coefficient for the same upper row
  // while the stored base radiance of that upper region is broadcast to all.

  logic                      in_fire;
  logic                      out_free;
  logic                      commit;
  logic                      emit;
  lrp_pkg::lrp_ctl_t         ctl;
  lrp_pkg::lrp_slot_t        slot;
  logic                      layer_load;
  logic                      coef_load;
  logic [lrp_pkg::RadW-1:0]  operand;

  logic [lrp_pkg::CoefW-1:0] lane_trans [lrp_pkg::RegionCount];
  logic [lrp_pkg::RadW-1:0]  lane_src   [lrp_pkg::RegionCount];
  logic [lrp_pkg::RadW-1:0]  lane_base  [lrp_pkg::RegionCount];

  // Base radiances of the layer above; the merge stage writes them back here.
  logic [lrp_pkg::RadW-1:0]  prev_base_q [lrp_pkg::RegionCount];

  logic                      out_valid_q;
  logic [lrp_pkg::RadW-1:0]  out_base_q [lrp_pkg::RegionCount];

  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign slot       = lrp_pkg::coef_slot(coef_index_i);
  assign coef_load  = in_fire && (cmd_i == lrp_pkg::CmdLoad) && slot.valid;
  assign layer_load = in_fire && (cmd_i == lrp_pkg::CmdLayer);

  assign lane_trans[0] = trans_clear_i;
  assign lane_trans[1] = trans_cloud_a_i;
  assign lane_trans[2] = trans_cloud_b_i;
  assign lane_src[0]   = src_clear_i;
  assign lane_src[1]   = src_cloud_a_i;
  assign lane_src[2]   = src_cloud_b_i;

  // The row index of the sequencer picks the upper region being mixed.
  always_comb begin
    case (ctl.row)
      2'd0:    operand = prev_base_q[0];
      2'd1:    operand = prev_base_q[1];
      2'd2:    operand = prev_base_q[2];
      default: operand = prev_base_q[0];
    endcase
  end

  lrp_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_fire_i     (in_fire),
    .cmd_i         (cmd_i),
    .layer_clear_i (layer_clear_i),
    .last_layer_i  (last_layer_i),
    .out_free_i    (out_free),
    .in_ready_o    (in_ready_o),
    .ctl_o         (ctl),
    .commit_o      (commit),
    .emit_o        (emit)
  );

  for (genvar g = 0; g < lrp_pkg::RegionCount; g++) begin : g_lane
    // A clear layer solves only the clear region; the cloudy bases are zero.
    lrp_lane u_lane (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .zero_base_i (ctl.layer_clear && (g != 0)),
      .load_i      (layer_load),
      .trans_i     (lane_trans[g]),
      .src_i       (lane_src[g]),
      .coef_we_i   (coef_load && (slot.lane == lrp_pkg::RowW'(g))),
      .coef_row_i  (slot.row),
      .coef_val_i  (coef_value_i),
      .operand_i   (operand),
      .base_o      (lane_base[g])
    );
  end

  // Merge stage: gather the lane results into the stored column state and,
  // for the bottom layer, into the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lrp_pkg::RegionCount; i++) begin
        prev_base_q[i] <= '0;
      end
    end else if (commit) begin
      for (int i = 0; i < lrp_pkg::RegionCount; i++) begin
        prev_base_q[i] <= lane_base[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      for (int i = 0; i < lrp_pkg::RegionCount; i++) begin
        out_base_q[i] <= lane_base[i];
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign base_clear_o   = out_base_q[0];
  assign base_cloud_a_o = out_base_q[1];
  assign base_cloud_b_o = out_base_q[2];

  `LRP_ASSERT(a_emit_needs_room, emit, out_free)
  `LRP_ASSERT(a_emit_is_commit, emit, commit)
  `LRP_ASSERT_NXT(a_commit_stores_base, commit,
      (prev_base_q[0] == $past(lane_base[0])) && (prev_base_q[2] == $past(lane_base[2])))

endmodule
